// ===== src/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, constants and helpers for the first-fit two-resource allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    localparam int NODE_COUNT = 128;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int VAL_W      = 8;
    localparam int ENTRY_W    = 2 * VAL_W;

    // configuration register indexes
    localparam logic [1:0] CFG_CORE_CAP = 2'd0;
    localparam logic [1:0] CFG_MEM_CAP  = 2'd1;
    localparam logic [1:0] CFG_NODES    = 2'd2;

    localparam logic [VAL_W-1:0] CORE_CAP_RESET = 8'd24;
    localparam logic [VAL_W-1:0] MEM_CAP_RESET  = 8'd64;
    localparam logic [VAL_W-1:0] NODES_RESET    = 8'd128;

    // request codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_PLACED   = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [1:0] STATUS_RELEASED = 2'd2;

    typedef struct packed {
        logic              op;
        logic [VAL_W-1:0]  demand_cores;
        logic [VAL_W-1:0]  demand_memory;
        logic [NODE_W-1:0] target_node;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] chosen_node;
        logic [VAL_W-1:0]  cores_left;
        logic [VAL_W-1:0]  memory_left;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL_RD,
        ST_REL_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_req;
        logic scan;
        logic rel_rd;
        logic rel_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_op;
        logic hit;
        logic exhaust;
        logic out_free;
    } sts_t;

    // capacity minus used, floored at zero
    function automatic logic [VAL_W-1:0] free_amt(input logic [VAL_W-1:0] cap,
                                                  input logic [VAL_W-1:0] used);
        logic [VAL_W-1:0] res;
        res = (cap > used) ? (cap - used) : '0;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for the allocator: scan, release read/write and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t      cmd
);

    ffa_pkg::state_t state_reg;
    ffa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (sts.in_op == ffa_pkg::OP_RELEASE) ?
                                 ffa_pkg::ST_REL_RD : ffa_pkg::ST_SCAN;
                end
            end
            ffa_pkg::ST_SCAN:
            begin
                if (sts.hit || sts.exhaust)
                begin
                    state_next = ffa_pkg::ST_DONE;
                end
            end
            ffa_pkg::ST_REL_RD: state_next = ffa_pkg::ST_REL_WR;
            ffa_pkg::ST_REL_WR: state_next = ffa_pkg::ST_DONE;
            ffa_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ffa_pkg::ST_IDLE;
                end
            end
            default: state_next = ffa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ffa_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            ffa_pkg::ST_SCAN:   cmd.scan     = 1'b1;
            ffa_pkg::ST_REL_RD: cmd.rel_rd   = 1'b1;
            ffa_pkg::ST_REL_WR: cmd.rel_wr   = 1'b1;
            ffa_pkg::ST_DONE:   cmd.out_load = sts.out_free;
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ffa_dp.sv =====
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath: configuration, node usage store, fit check and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire ffa_pkg::in_t  in_data,
    output ffa_pkg::out_t      out_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire ffa_pkg::cmd_t cmd,
    output ffa_pkg::sts_t      sts
);

    localparam int NW = ffa_pkg::NODE_W;
    localparam int CW = ffa_pkg::CNT_W;
    localparam int VW = ffa_pkg::VAL_W;

    logic [VW-1:0] core_cap_reg, core_cap_next;
    logic [VW-1:0] mem_cap_reg,  mem_cap_next;
    logic [VW-1:0] nodes_reg,    nodes_next;

    ffa_pkg::in_t  req_reg, req_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic [NW-1:0] chk_idx_reg, chk_idx_next;
    logic          chk_live_reg, chk_live_next;
    logic          vq_reg, vq_next;
    ffa_pkg::out_t res_reg, res_next;
    ffa_pkg::out_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    logic [ffa_pkg::NODE_COUNT-1:0] vld_reg, vld_next;

    logic [CW-1:0]               limit;
    logic                        issue;
    logic                        re;
    logic [NW-1:0]               raddr;
    logic                        we;
    logic [NW-1:0]               waddr;
    logic [ffa_pkg::ENTRY_W-1:0] wdata;
    logic [ffa_pkg::ENTRY_W-1:0] rdata;
    logic [VW-1:0]               used_c, used_m;
    logic [VW-1:0]               fc, fm;
    logic                        fit;
    logic [VW-1:0]               rel_c, rel_m;

    // config registers
    always_comb
    begin
        core_cap_next = core_cap_reg;
        mem_cap_next  = mem_cap_reg;
        nodes_next    = nodes_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ffa_pkg::CFG_CORE_CAP: core_cap_next = cfg_data;
                ffa_pkg::CFG_MEM_CAP:  mem_cap_next  = cfg_data;
                ffa_pkg::CFG_NODES:    nodes_next    = cfg_data;
                default: ;
            endcase
        end
    end

    // search window and read issue
    assign limit = (nodes_reg > VW'(ffa_pkg::NODE_COUNT)) ?
                   CW'(ffa_pkg::NODE_COUNT) : CW'(nodes_reg);
    assign issue = cmd.scan && (scan_addr_reg < limit);
    assign re    = issue || cmd.rel_rd;
    assign raddr = cmd.rel_rd ? req_reg.target_node : scan_addr_reg[NW-1:0];

    // entry never written reads as all zero
    assign used_c = vq_reg ? rdata[ffa_pkg::ENTRY_W-1:VW] : '0;
    assign used_m = vq_reg ? rdata[VW-1:0] : '0;
    assign fc     = ffa_pkg::free_amt(core_cap_reg, used_c);
    assign fm     = ffa_pkg::free_amt(mem_cap_reg, used_m);
    assign fit    = (fc >= req_reg.demand_cores) && (fm >= req_reg.demand_memory);

    assign rel_c = (used_c > req_reg.demand_cores) ? (used_c - req_reg.demand_cores) : '0;
    assign rel_m = (used_m > req_reg.demand_memory) ? (used_m - req_reg.demand_memory) : '0;

    assign sts.in_op    = in_data.op;
    assign sts.hit      = cmd.scan && chk_live_reg && fit;
    assign sts.exhaust  = cmd.scan && !issue && !chk_live_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        we    = 1'b0;
        waddr = chk_idx_reg;
        wdata = {used_c + req_reg.demand_cores, used_m + req_reg.demand_memory};
        if (cmd.rel_wr)
        begin
            we    = 1'b1;
            waddr = req_reg.target_node;
            wdata = {rel_c, rel_m};
        end
        else if (sts.hit)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        req_next       = req_reg;
        scan_addr_next = scan_addr_reg;
        chk_idx_next   = chk_idx_reg;
        chk_live_next  = chk_live_reg;
        vq_next        = vq_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        vld_next       = vld_reg;

        if (cmd.load_req)
        begin
            req_next       = in_data;
            scan_addr_next = '0;
            chk_live_next  = 1'b0;
        end
        if (cmd.scan)
        begin
            chk_live_next = issue;
            if (issue)
            begin
                scan_addr_next = scan_addr_reg + CW'(1);
                chk_idx_next   = scan_addr_reg[NW-1:0];
            end
        end
        if (re)
        begin
            vq_next = vld_reg[raddr];
        end
        if (we)
        begin
            vld_next[waddr] = 1'b1;
        end

        if (sts.hit)
        begin
            res_next.status      = ffa_pkg::STATUS_PLACED;
            res_next.chosen_node = chk_idx_reg;
            res_next.cores_left  = fc - req_reg.demand_cores;
            res_next.memory_left = fm - req_reg.demand_memory;
        end
        else if (sts.exhaust)
        begin
            res_next = '0;
            res_next.status = ffa_pkg::STATUS_NO_FIT;
        end
        else if (cmd.rel_wr)
        begin
            res_next.status      = ffa_pkg::STATUS_RELEASED;
            res_next.chosen_node = req_reg.target_node;
            res_next.cores_left  = ffa_pkg::free_amt(core_cap_reg, rel_c);
            res_next.memory_left = ffa_pkg::free_amt(mem_cap_reg, rel_m);
        end

        if (cmd.out_load)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_cap_reg  <= ffa_pkg::CORE_CAP_RESET;
            mem_cap_reg   <= ffa_pkg::MEM_CAP_RESET;
            nodes_reg     <= ffa_pkg::NODES_RESET;
            scan_addr_reg <= '0;
            chk_live_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            core_cap_reg  <= core_cap_next;
            mem_cap_reg   <= mem_cap_next;
            nodes_reg     <= nodes_next;
            scan_addr_reg <= scan_addr_next;
            chk_live_reg  <= chk_live_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        chk_idx_reg <= chk_idx_next;
        vq_reg      <= vq_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    ffa_ram #(
        .WIDTH (ffa_pkg::ENTRY_W),
        .DEPTH (ffa_pkg::NODE_COUNT)
    ) u_usage_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/first_fit_two_resource_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_two_resource_allocator_core
// First-fit placement of core/memory demands over a pool of worker nodes.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  in        in    in_valid / in_ready   ffa_pkg::in_t  in_data
//  out       out   out_valid / out_ready ffa_pkg::out_t out_data
//  cfg       in    cfg_we                cfg_index, cfg_data
//
//  allocate: the usage ram is read node by node from node 0 up, and the first node
//  with room for both demands is chosen; a miss searches min(nodes_in_use, 128)
//  nodes, one usage-ram read per node.
//  release: read, update, result. one transaction in flight at a time.
//  reset clears per-node valid bits at once, so no clearing pass is needed.
//  a stalled result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_two_resource_allocator_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ffa_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ffa_pkg::out_t      out_data
);

    ffa_pkg::cmd_t cmd;
    ffa_pkg::sts_t sts;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== src/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire ffa_pkg::out_t out_data
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one request in flight: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ffa_pkg::STATUS_PLACED ||
                       out_data.status == ffa_pkg::STATUS_NO_FIT ||
                       out_data.status == ffa_pkg::STATUS_RELEASED))
        else $error("undefined status code");

    // a miss carries no node and no free amounts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ffa_pkg::STATUS_NO_FIT |->
            out_data.chosen_node == '0 && out_data.cores_left == '0 &&
            out_data.memory_left == '0)
        else $error("miss result not cleared");

endmodule

bind first_fit_two_resource_allocator_core ffa_checker u_ffa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/placement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placement_checker
// Watches the register, request and result ports of the allocator, keeps its
// own copy of the per-node usage table and compares each result, in order,
// against the placement it predicts for the matching request.
// ----------------------------------------------------------------------------
module placement_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          in_valid,
    input  wire logic          in_ready,
    input  wire ffa_pkg::in_t  in_data,
    input  wire logic          out_valid,
    input  wire logic          out_ready,
    input  wire ffa_pkg::out_t out_data,
    output int                 pending,
    output int                 failures,
    output int                 placed_total,
    output int                 miss_total,
    output int                 release_total
);

    import ffa_pkg::*;

    logic [VAL_W-1:0] core_cap;
    logic [VAL_W-1:0] mem_cap;
    logic [VAL_W-1:0] nodes_on;
    logic [VAL_W-1:0] cores_taken  [NODE_COUNT];
    logic [VAL_W-1:0] memory_taken [NODE_COUNT];

    out_t placements_due [$];
    out_t oldest;
    out_t fresh;
    int   fail_tally;
    int   placed_tally;
    int   miss_tally;
    int   release_tally;

    function automatic logic [VAL_W-1:0] headroom(input logic [VAL_W-1:0] cap,
                                                  input logic [VAL_W-1:0] used);
        return (cap > used) ? cap - used : '0;
    endfunction

    function automatic logic [VAL_W-1:0] give_back(input logic [VAL_W-1:0] used,
                                                   input logic [VAL_W-1:0] back);
        return (used > back) ? used - back : '0;
    endfunction

    // updates the usage table and returns the result the block owes
    function automatic out_t place_request(input in_t req);
        out_t             res;
        int               span;
        int               n;
        logic             found;
        logic [VAL_W-1:0] fc;
        logic [VAL_W-1:0] fm;
        res = '0;
        if (req.op == OP_ALLOC)
        begin
            res.status = STATUS_NO_FIT;
            span = (nodes_on < NODE_COUNT) ? int'(nodes_on) : NODE_COUNT;
            found = 1'b0;
            n = 0;
            while (n < span && !found)
            begin
                fc = headroom(core_cap, cores_taken[n]);
                fm = headroom(mem_cap, memory_taken[n]);
                if (fc >= req.demand_cores && fm >= req.demand_memory)
                begin
                    cores_taken[n]  = cores_taken[n] + req.demand_cores;
                    memory_taken[n] = memory_taken[n] + req.demand_memory;
                    res.status      = STATUS_PLACED;
                    res.chosen_node = NODE_W'(n);
                    res.cores_left  = fc - req.demand_cores;
                    res.memory_left = fm - req.demand_memory;
                    found = 1'b1;
                end
                n++;
            end
        end
        else
        begin
            // a 7-bit target always lands inside the 128-node pool
            cores_taken[req.target_node]  = give_back(cores_taken[req.target_node],
                                                      req.demand_cores);
            memory_taken[req.target_node] = give_back(memory_taken[req.target_node],
                                                      req.demand_memory);
            res.status      = STATUS_RELEASED;
            res.chosen_node = req.target_node;
            res.cores_left  = headroom(core_cap, cores_taken[req.target_node]);
            res.memory_left = headroom(mem_cap, memory_taken[req.target_node]);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_cap = CORE_CAP_RESET;
            mem_cap  = MEM_CAP_RESET;
            nodes_on = NODES_RESET;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                cores_taken[i]  = '0;
                memory_taken[i] = '0;
            end
            placements_due.delete();
            fail_tally    = 0;
            placed_tally  = 0;
            miss_tally    = 0;
            release_tally = 0;
            pending       <= 0;
            failures      <= 0;
            placed_total  <= 0;
            miss_total    <= 0;
            release_total <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CORE_CAP: core_cap = cfg_data;
                    CFG_MEM_CAP:  mem_cap  = cfg_data;
                    CFG_NODES:    nodes_on = cfg_data;
                    default:      ;
                endcase
            end

            // a result never belongs to a request taken at the same edge
            if (out_valid && out_ready)
            begin
                if (placements_due.size() == 0)
                begin
                    $display("%0t: result with none outstanding, expected nothing, got %p",
                             $time, out_data);
                    fail_tally++;
                end
                else
                begin
                    oldest = placements_due.pop_front();
                    check_field("status", 8'(oldest.status), 8'(out_data.status));
                    check_field("chosen_node", 8'(oldest.chosen_node),
                                8'(out_data.chosen_node));
                    check_field("cores_left", oldest.cores_left, out_data.cores_left);
                    check_field("memory_left", oldest.memory_left, out_data.memory_left);
                end
            end

            if (in_valid && in_ready)
            begin
                fresh = place_request(in_data);
                placements_due.insert(placements_due.size(), fresh);
                case (fresh.status)
                    STATUS_PLACED:   placed_tally++;
                    STATUS_NO_FIT:   miss_tally++;
                    default:         release_tally++;
                endcase
            end

            pending       <= placements_due.size();
            failures      <= fail_tally;
            placed_total  <= placed_tally;
            miss_total    <= miss_tally;
            release_total <= release_tally;
        end
    end

endmodule

// ===== tb/tb_first_fit_two_resource_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_two_resource_allocator_core
// Drives allocate and release transactions through the allocator under a
// series of capacity and pool-size settings, with random gaps and stalls on
// both channels and one long result hold-off; placement_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_first_fit_two_resource_allocator_core;

    import ffa_pkg::*;

    localparam int         HOLD_CYCLES = 400;
    localparam int         IDLE_PCT    = 16;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    logic hold_req;
    logic hold_done;
    logic steady;
    int   cur_core;
    int   cur_mem;
    int   cur_nodes;
    int   settings_used;
    int   items_sent;

    int pending;
    int failures;
    int placed_total;
    int miss_total;
    int release_total;

    first_fit_two_resource_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    placement_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .pending       (pending),
        .failures      (failures),
        .placed_total  (placed_total),
        .miss_total    (miss_total),
        .release_total (release_total)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic in_t make_req(input logic op, input int dc, input int dm,
                                     input int tn);
        in_t req;
        req.op            = op;
        req.demand_cores  = 8'(dc);
        req.demand_memory = 8'(dm);
        req.target_node   = NODE_W'(tn);
        return req;
    endfunction

    // demands scaled to the current capacities, now and then anything at all
    function automatic in_t random_request();
        in_t req;
        int  span;
        span = (cur_nodes < NODE_COUNT) ? cur_nodes : NODE_COUNT;
        if (span == 0)
            span = 1;
        req.op = ($urandom_range(99) < 60) ? OP_ALLOC : OP_RELEASE;
        if ($urandom_range(9) == 0)
        begin
            req.demand_cores  = 8'($urandom);
            req.demand_memory = 8'($urandom);
        end
        else
        begin
            req.demand_cores  = 8'($urandom_range((cur_core + 2) / 3));
            req.demand_memory = 8'($urandom_range((cur_mem + 2) / 3));
        end
        if ($urandom_range(4) == 0)
            req.target_node = NODE_W'($urandom);
        else
            req.target_node = NODE_W'($urandom_range(span - 1));
        return req;
    endfunction

    task automatic send_request(input in_t req);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(input int core, input int mem, input int nodes);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CORE_CAP;
        cfg_data  <= 8'(core);
        @(posedge clk);
        cfg_index <= CFG_MEM_CAP;
        cfg_data  <= 8'(mem);
        @(posedge clk);
        cfg_index <= CFG_NODES;
        cfg_data  <= 8'(nodes);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_core  = core;
        cur_mem   = mem;
        cur_nodes = nodes;
        settings_used++;
    endtask

    // result side: random stalls, one long hold-off, ready throughout when steady
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL first_fit_two_resource_allocator_core");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_CORE_CAP;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        hold_req      = 1'b0;
        steady        = 1'b0;
        cur_core      = CORE_CAP_RESET;
        cur_mem       = MEM_CAP_RESET;
        cur_nodes     = NODES_RESET;
        settings_used = 1;
        items_sent    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacities: zero demand, a full node, oversize demands, saturation
        send_request(make_req(OP_ALLOC, 0, 0, 0));
        send_request(make_req(OP_ALLOC, 24, 64, 0));
        send_request(make_req(OP_ALLOC, 0, 0, 127));
        send_request(make_req(OP_ALLOC, 1, 1, 0));
        send_request(make_req(OP_ALLOC, 255, 0, 0));
        send_request(make_req(OP_ALLOC, 0, 255, 0));
        send_request(make_req(OP_ALLOC, 255, 255, 127));
        send_request(make_req(OP_RELEASE, 255, 255, 0));
        send_request(make_req(OP_RELEASE, 255, 255, 127));
        send_request(make_req(OP_ALLOC, 24, 0, 0));
        send_request(make_req(OP_RELEASE, 1, 0, 1));
        send_request(make_req(OP_ALLOC, 23, 63, 0));

        // hold results back while requests keep coming
        hold_req <= 1'b1;
        run_random(12);
        run_random(90);

        // small pool: fill every node, miss, free one, release outside the search
        set_registers(8, 16, 4);
        send_request(make_req(OP_RELEASE, 3, 3, 100));
        repeat (5) send_request(make_req(OP_ALLOC, 8, 16, 0));
        send_request(make_req(OP_RELEASE, 8, 16, 2));
        send_request(make_req(OP_ALLOC, 1, 1, 0));
        run_random(80);

        // capacities dropped below usage, pool size beyond the node count
        set_registers(4, 8, 200);
        send_request(make_req(OP_ALLOC, 0, 0, 0));
        send_request(make_req(OP_ALLOC, 1, 0, 0));
        run_random(50);

        steady <= 1'b1;
        set_registers(255, 255, 1);
        run_random(50);
        steady <= 1'b0;

        set_registers(1, 1, 128);
        run_random(40);

        // nothing searched and nothing free
        set_registers(0, 0, 0);
        send_request(make_req(OP_ALLOC, 0, 0, 0));
        send_request(make_req(OP_RELEASE, 2, 5, 5));
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE;
        cfg_data  <= 8'hA5;
        @(posedge clk);
        cfg_we    <= 1'b0;
        set_registers(0, 10, 3);
        send_request(make_req(OP_ALLOC, 0, 5, 0));
        send_request(make_req(OP_ALLOC, 0, 0, 0));
        run_random(30);

        set_registers(CORE_CAP_RESET, MEM_CAP_RESET, NODES_RESET);
        run_random(60);

        drain_results();
        repeat (16) @(posedge clk);
        $display("%0d transactions over %0d register settings:",
                 items_sent, settings_used);
        $display("%0d placed, %0d no fit, %0d released, with a %0d-cycle result hold-off",
                 placed_total, miss_total, release_total, HOLD_CYCLES);
        if (failures == 0)
            $display("PASS first_fit_two_resource_allocator_core");
        else
            $display("FAIL first_fit_two_resource_allocator_core");
        $finish;
    end

endmodule
